@@ sv/complex_arith_unit_core_defines.svh @@
// Assertion macros for the complex arithmetic unit.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cau_pkg.sv @@
// Package for the complex arithmetic unit: constants, operation codes,
// pipeline payload types and shared arithmetic helpers. No dependencies.
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QB        = 33;
    localparam int CW        = 36;
    localparam int NCH       = 33;
    localparam int NSQ       = 32;
    localparam int NCD       = 31;
    localparam int STW       = 5;

    localparam logic signed [CW-1:0] PI_Q30 = CW'(64'd3373259426);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4,
        OP_ANG = 3'd5,
        OP_SEL = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef struct packed {
        logic [63:0]    rem;
        logic [QB-1:0]  sh;
        logic [QB-1:0]  q;
    } t_div;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sqrt;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_s32;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_sm;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic [63:0]        p_rr;
        logic [63:0]        p_ii;
        logic [63:0]        p_ri;
        logic [63:0]        p_ir;
        logic [63:0]        s_aa;
        logic [63:0]        s_ai;
        logic [63:0]        s_bb;
        logic [63:0]        s_bi;
        logic signed [31:0] e_re;
        logic signed [31:0] e_im;
        t_status            e_st;
    } t_s1;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic signed [31:0] e_re;
        logic signed [31:0] e_im;
        t_status            e_st;
        t_sm                m_re;
        t_sm                m_im;
        t_sm                d_re;
        t_sm                d_im;
        logic [63:0]        den;
        logic [63:0]        maga;
        logic [63:0]        magb;
    } t_s2;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] e_re;
        logic signed [31:0] e_im;
        t_status            e_st;
        logic [63:0]        den;
        logic               zden;
        t_div               dre;
        t_div               dim;
        logic               neg_re;
        logic               neg_im;
        logic               big_re;
        logic               big_im;
        t_sqrt              sq;
        t_cordic            cd;
        logic               czero;
    } t_ch;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] e_re;
        logic signed [31:0] e_im;
        t_status            e_st;
        logic               zden;
        logic [QB:0]        qr_re;
        logic               neg_re;
        logic               big_re;
        logic [QB:0]        qr_im;
        logic               neg_im;
        logic               big_im;
        logic [32:0]        sq_r;
        logic signed [31:0] ang;
    } t_rd;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        t_status            st;
        t_op                op;
    } t_rsp;

    function automatic logic signed [CW-1:0] atan_q30(input logic [STW-1:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:    v = CW'(843314856);
            5'd1:    v = CW'(497837829);
            5'd2:    v = CW'(263043836);
            5'd3:    v = CW'(133525158);
            5'd4:    v = CW'(67021686);
            5'd5:    v = CW'(33543515);
            5'd6:    v = CW'(16775850);
            5'd7:    v = CW'(8388437);
            5'd8:    v = CW'(4194282);
            5'd9:    v = CW'(2097149);
            5'd10:   v = CW'(1048575);
            5'd11:   v = CW'(524287);
            5'd12:   v = CW'(262143);
            5'd13:   v = CW'(131071);
            5'd14:   v = CW'(65535);
            5'd15:   v = CW'(32767);
            5'd16:   v = CW'(16383);
            5'd17:   v = CW'(8191);
            5'd18:   v = CW'(4095);
            5'd19:   v = CW'(2047);
            5'd20:   v = CW'(1023);
            5'd21:   v = CW'(511);
            5'd22:   v = CW'(255);
            5'd23:   v = CW'(127);
            5'd24:   v = CW'(63);
            5'd25:   v = CW'(31);
            5'd26:   v = CW'(15);
            5'd27:   v = CW'(8);
            5'd28:   v = CW'(4);
            5'd29:   v = CW'(2);
            5'd30:   v = CW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_s32 to_s32(input logic neg, input logic [63:0] mag);
        t_s32 o;
        o.sat = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                o.sat = 1'b1;
                o.val = 32'h8000_0000;
            end else begin
                o.val = 32'(-mag);
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                o.sat = 1'b1;
                o.val = 32'h7FFF_FFFF;
            end else begin
                o.val = mag[31:0];
            end
        end
        return o;
    endfunction

    function automatic t_s32 sat33(input logic [32:0] s);
        t_s32 o;
        o.sat = (s[32] != s[31]);
        if (!o.sat) begin
            o.val = s[31:0];
        end else if (s[32]) begin
            o.val = 32'h8000_0000;
        end else begin
            o.val = 32'h7FFF_FFFF;
        end
        return o;
    endfunction

    function automatic t_sm sm65(input logic [64:0] s);
        t_sm o;
        logic [64:0] n;
        n = -s;
        o.neg = s[64];
        o.mag = s[64] ? n[63:0] : s[63:0];
        return o;
    endfunction

endpackage

@@ sv/cau_if.sv @@
// Request and response channel interfaces for the complex arithmetic unit.
// Valid/ready handshake; no dependencies.
interface cau_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [1:0]         status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

@@ sv/complex_arith_unit_core.sv @@
// Complex arithmetic unit top level: product, setup, step chain and output stages.
// One request per cycle is accepted while the skid stage is empty.
// The step chain is the 33-step quotient chain, which the root and CORDIC share.
// A two-entry output register and skid stage hold results while the sink stalls.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// Depends on cau_pkg, cau_if, the step modules and the assertion macro header.
`include "complex_arith_unit_core_defines.svh"

module complex_arith_unit_core
    import cau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_req_if.sink   i_req,
    cau_rsp_if.source o_rsp
);

    logic w_en;

    logic r_v_s1;
    logic r_v_s2;
    logic [NCH:0] r_v_ch;
    logic r_v_rd;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_ch  r_ch [0:NCH];
    t_ch  n_ch [0:NCH];
    t_rd  r_rd, n_rd;
    t_rsp w_fin;
    t_rsp r_out, r_skid;
    logic r_out_v, r_skid_v;

    logic signed [63:0] w_prr, w_pii, w_pri, w_pir, w_saa, w_sai, w_sbb, w_sbi;

    assign w_en        = !r_skid_v;
    assign i_req.ready = w_en;

    assign w_prr = i_req.a_re * i_req.b_re;
    assign w_pii = i_req.a_im * i_req.b_im;
    assign w_pri = i_req.a_re * i_req.b_im;
    assign w_pir = i_req.a_im * i_req.b_re;
    assign w_saa = i_req.a_re * i_req.a_re;
    assign w_sai = i_req.a_im * i_req.a_im;
    assign w_sbb = i_req.b_re * i_req.b_re;
    assign w_sbi = i_req.b_im * i_req.b_im;

    always_comb begin
        t_s32 re_s, im_s;
        logic [32:0] re_w, im_w;
        n_s1.op   = t_op'(i_req.req_type);
        n_s1.ar   = i_req.a_re;
        n_s1.ai   = i_req.a_im;
        n_s1.br   = i_req.b_re;
        n_s1.bi   = i_req.b_im;
        n_s1.p_rr = w_prr;
        n_s1.p_ii = w_pii;
        n_s1.p_ri = w_pri;
        n_s1.p_ir = w_pir;
        n_s1.s_aa = w_saa;
        n_s1.s_ai = w_sai;
        n_s1.s_bb = w_sbb;
        n_s1.s_bi = w_sbi;
        if (n_s1.op == OP_SUB) begin
            re_w = {i_req.a_re[31], i_req.a_re} - {i_req.b_re[31], i_req.b_re};
            im_w = {i_req.a_im[31], i_req.a_im} - {i_req.b_im[31], i_req.b_im};
        end else begin
            re_w = {i_req.a_re[31], i_req.a_re} + {i_req.b_re[31], i_req.b_re};
            im_w = {i_req.a_im[31], i_req.a_im} + {i_req.b_im[31], i_req.b_im};
        end
        re_s = sat33(re_w);
        im_s = sat33(im_w);
        n_s1.e_re = '0;
        n_s1.e_im = '0;
        n_s1.e_st = ST_OK;
        if (n_s1.op == OP_ADD || n_s1.op == OP_SUB) begin
            n_s1.e_re = re_s.val;
            n_s1.e_im = im_s.val;
            n_s1.e_st = (re_s.sat || im_s.sat) ? ST_SAT : ST_OK;
        end
    end

    always_comb begin
        n_s2.op   = r_s1.op;
        n_s2.ar   = r_s1.ar;
        n_s2.ai   = r_s1.ai;
        n_s2.br   = r_s1.br;
        n_s2.bi   = r_s1.bi;
        n_s2.e_re = r_s1.e_re;
        n_s2.e_im = r_s1.e_im;
        n_s2.e_st = r_s1.e_st;
        n_s2.m_re = sm65({r_s1.p_rr[63], r_s1.p_rr} - {r_s1.p_ii[63], r_s1.p_ii});
        n_s2.m_im = sm65({r_s1.p_ri[63], r_s1.p_ri} + {r_s1.p_ir[63], r_s1.p_ir});
        n_s2.d_re = sm65({r_s1.p_rr[63], r_s1.p_rr} + {r_s1.p_ii[63], r_s1.p_ii});
        n_s2.d_im = sm65({r_s1.p_ir[63], r_s1.p_ir} - {r_s1.p_ri[63], r_s1.p_ri});
        n_s2.den  = r_s1.s_bb + r_s1.s_bi;
        n_s2.maga = r_s1.s_aa + r_s1.s_ai;
        n_s2.magb = r_s1.s_bb + r_s1.s_bi;
    end

    always_comb begin
        logic [64:0] t_re, t_im;
        t_s32 mr, mi;
        logic [63:0] ir, ii;
        t_re = {1'b0, r_s2.m_re.mag} + (65'd1 << (FRAC_BITS - 1));
        t_im = {1'b0, r_s2.m_im.mag} + (65'd1 << (FRAC_BITS - 1));
        mr   = to_s32(r_s2.m_re.neg, 64'(t_re >> FRAC_BITS));
        mi   = to_s32(r_s2.m_im.neg, 64'(t_im >> FRAC_BITS));
        ir   = r_s2.d_re.mag >> (QB - FRAC_BITS);
        ii   = r_s2.d_im.mag >> (QB - FRAC_BITS);

        n_ch[0].op   = r_s2.op;
        n_ch[0].e_re = r_s2.e_re;
        n_ch[0].e_im = r_s2.e_im;
        n_ch[0].e_st = r_s2.e_st;
        if (r_s2.op == OP_MUL) begin
            n_ch[0].e_re = mr.val;
            n_ch[0].e_im = mi.val;
            n_ch[0].e_st = (mr.sat || mi.sat) ? ST_SAT : ST_OK;
        end else if (r_s2.op == OP_SEL) begin
            n_ch[0].e_st = ST_OK;
            if (r_s2.maga > r_s2.magb) begin
                n_ch[0].e_re = r_s2.ar;
                n_ch[0].e_im = r_s2.ai;
            end else begin
                n_ch[0].e_re = r_s2.br;
                n_ch[0].e_im = r_s2.bi;
            end
        end

        n_ch[0].den      = r_s2.den;
        n_ch[0].zden     = (r_s2.den == '0);
        n_ch[0].dre.rem  = ir;
        n_ch[0].dre.sh   = QB'({r_s2.d_re.mag, {FRAC_BITS{1'b0}}});
        n_ch[0].dre.q    = '0;
        n_ch[0].dim.rem  = ii;
        n_ch[0].dim.sh   = QB'({r_s2.d_im.mag, {FRAC_BITS{1'b0}}});
        n_ch[0].dim.q    = '0;
        n_ch[0].neg_re   = r_s2.d_re.neg;
        n_ch[0].neg_im   = r_s2.d_im.neg;
        n_ch[0].big_re   = (ir >= r_s2.den);
        n_ch[0].big_im   = (ii >= r_s2.den);
        n_ch[0].sq.v     = r_s2.maga;
        n_ch[0].sq.r     = '0;

        n_ch[0].cd.x  = {{(CW-32){r_s2.ar[31]}}, r_s2.ar};
        n_ch[0].cd.y  = {{(CW-32){r_s2.ai[31]}}, r_s2.ai};
        n_ch[0].cd.z  = '0;
        n_ch[0].czero = (r_s2.ai == '0) && !r_s2.ar[31];
        if (r_s2.ar[31]) begin
            n_ch[0].cd.z = r_s2.ai[31] ? -PI_Q30 : PI_Q30;
            n_ch[0].cd.x = -n_ch[0].cd.x;
            n_ch[0].cd.y = -n_ch[0].cd.y;
        end
    end

    for (genvar k = 0; k < NCH; k++) begin : g_ch
        t_div    w_dre, w_dim;
        t_sqrt   w_sq;
        t_cordic w_cd;

        cau_div_step u_div_re (.i_lane(r_ch[k].dre), .i_den(r_ch[k].den), .o_lane(w_dre));
        cau_div_step u_div_im (.i_lane(r_ch[k].dim), .i_den(r_ch[k].den), .o_lane(w_dim));

        if (k < NSQ) begin : g_sq
            cau_sqrt_step u_sqrt (.i_lane(r_ch[k].sq), .i_step(STW'(k)), .o_lane(w_sq));
        end else begin : g_sq_pass
            assign w_sq = r_ch[k].sq;
        end

        if (k < NCD) begin : g_cd
            cau_cordic_step u_cordic (.i_lane(r_ch[k].cd), .i_step(STW'(k)), .o_lane(w_cd));
        end else begin : g_cd_pass
            assign w_cd = r_ch[k].cd;
        end

        always_comb begin
            n_ch[k+1]     = r_ch[k];
            n_ch[k+1].dre = w_dre;
            n_ch[k+1].dim = w_dim;
            n_ch[k+1].sq  = w_sq;
            n_ch[k+1].cd  = w_cd;
        end
    end

    for (genvar k = 0; k <= NCH; k++) begin : g_ch_reg
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ch[k] <= n_ch[k];
            end
        end
    end

    always_comb begin
        logic rb_re, rb_im;
        logic signed [CW-1:0] zr, zs;
        rb_re = {r_ch[NCH].dre.rem, 1'b0} >= {1'b0, r_ch[NCH].den};
        rb_im = {r_ch[NCH].dim.rem, 1'b0} >= {1'b0, r_ch[NCH].den};
        zr    = r_ch[NCH].cd.z + (CW'(1) << (29 - FRAC_BITS));
        zs    = zr >>> (30 - FRAC_BITS);

        n_rd.op     = r_ch[NCH].op;
        n_rd.e_re   = r_ch[NCH].e_re;
        n_rd.e_im   = r_ch[NCH].e_im;
        n_rd.e_st   = r_ch[NCH].e_st;
        n_rd.zden   = r_ch[NCH].zden;
        n_rd.qr_re  = {1'b0, r_ch[NCH].dre.q} + {{QB{1'b0}}, rb_re};
        n_rd.qr_im  = {1'b0, r_ch[NCH].dim.q} + {{QB{1'b0}}, rb_im};
        n_rd.neg_re = r_ch[NCH].neg_re;
        n_rd.neg_im = r_ch[NCH].neg_im;
        n_rd.big_re = r_ch[NCH].big_re;
        n_rd.big_im = r_ch[NCH].big_im;
        n_rd.sq_r   = r_ch[NCH].sq.r[32:0];
        n_rd.ang    = r_ch[NCH].czero ? 32'sd0 : zs[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_s1 <= 1'b0;
            r_v_s2 <= 1'b0;
            r_v_ch <= '0;
            r_v_rd <= 1'b0;
        end else if (w_en) begin
            r_v_s1 <= i_req.valid;
            r_v_s2 <= r_v_s1;
            r_v_ch <= {r_v_ch[NCH-1:0], r_v_s2};
            r_v_rd <= r_v_ch[NCH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_rd <= n_rd;
        end
    end

    always_comb begin
        t_s32 dr, di, sq;
        dr = to_s32(r_rd.neg_re, r_rd.big_re ? '1 : 64'(r_rd.qr_re));
        di = to_s32(r_rd.neg_im, r_rd.big_im ? '1 : 64'(r_rd.qr_im));
        sq = to_s32(1'b0, 64'(r_rd.sq_r));
        w_fin.op = r_rd.op;
        w_fin.re = '0;
        w_fin.im = '0;
        w_fin.st = ST_OK;
        unique case (r_rd.op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_SEL: begin
                w_fin.re = r_rd.e_re;
                w_fin.im = r_rd.e_im;
                w_fin.st = r_rd.e_st;
            end
            OP_DIV: begin
                if (r_rd.zden) begin
                    w_fin.st = ST_DIV_ZERO;
                end else begin
                    w_fin.re = dr.val;
                    w_fin.im = di.val;
                    w_fin.st = (dr.sat || di.sat) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                w_fin.re = sq.val;
                w_fin.st = sq.sat ? ST_SAT : ST_OK;
            end
            OP_ANG: begin
                w_fin.re = r_rd.ang;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_rsp.ready) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || o_rsp.ready) begin
            r_out_v <= r_v_rd;
            r_out   <= w_fin;
        end else if (r_v_rd) begin
            r_skid_v <= 1'b1;
            r_skid   <= w_fin;
        end
    end

    assign o_rsp.valid  = r_out_v;
    assign o_rsp.res_re = r_out.re;
    assign o_rsp.res_im = r_out.im;
    assign o_rsp.status = r_out.st;

    `CAU_ASSERT_IMP(a_div_zero_clears, o_rsp.valid && (o_rsp.status == ST_DIV_ZERO), (o_rsp.res_re == 32'sd0) && (o_rsp.res_im == 32'sd0), "divide-by-zero response carries a nonzero result")
    `CAU_ASSERT_IMP(a_scalar_im_zero, o_rsp.valid && ((r_out.op == OP_MAG) || (r_out.op == OP_ANG)), o_rsp.res_im == 32'sd0, "magnitude or angle response has a nonzero imaginary part")
    `CAU_ASSERT_NXT(a_accept_enters, i_req.valid && i_req.ready, r_v_s1, "accepted transaction did not enter the first stage")
    `CAU_ASSERT_IMP(a_skid_needs_out, r_skid_v, r_out_v, "skid stage holds a transaction while the output register is empty")

endmodule

@@ sv/cau_div_step.sv @@
// One restoring division step: shifts in one dividend bit, yields one quotient bit.
// Depends on cau_pkg.
module cau_div_step
    import cau_pkg::*;
(
    input  t_div        i_lane,
    input  logic [63:0] i_den,
    output t_div        o_lane
);

    logic [64:0] w_rem2;
    logic [64:0] w_den;

    assign w_rem2 = {i_lane.rem, i_lane.sh[QB-1]};
    assign w_den  = {1'b0, i_den};

    always_comb begin
        o_lane.sh = i_lane.sh << 1;
        if (w_rem2 >= w_den) begin
            o_lane.rem = 64'(w_rem2 - w_den);
            o_lane.q   = {i_lane.q[QB-2:0], 1'b1};
        end else begin
            o_lane.rem = w_rem2[63:0];
            o_lane.q   = {i_lane.q[QB-2:0], 1'b0};
        end
    end

endmodule

@@ sv/cau_sqrt_step.sv @@
// One digit-by-digit integer square root step, two radicand bits per step.
// Depends on cau_pkg.
module cau_sqrt_step
    import cau_pkg::*;
(
    input  t_sqrt          i_lane,
    input  logic [STW-1:0] i_step,
    output t_sqrt          o_lane
);

    logic [6:0]  w_sh;
    logic [63:0] w_bit;
    logic [63:0] w_sum;

    assign w_sh  = 7'd62 - {1'b0, i_step, 1'b0};
    assign w_bit = 64'd1 << w_sh;
    assign w_sum = i_lane.r + w_bit;

    always_comb begin
        if (i_lane.v >= w_sum) begin
            o_lane.v = i_lane.v - w_sum;
            o_lane.r = (i_lane.r >> 1) + w_bit;
        end else begin
            o_lane.v = i_lane.v;
            o_lane.r = i_lane.r >> 1;
        end
    end

endmodule

@@ sv/cau_cordic_step.sv @@
// One vectoring CORDIC rotation step for the angle operation.
// Depends on cau_pkg for the arctangent table.
module cau_cordic_step
    import cau_pkg::*;
(
    input  t_cordic        i_lane,
    input  logic [STW-1:0] i_step,
    output t_cordic        o_lane
);

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [CW-1:0] w_at;

    assign w_dx = i_lane.y >>> i_step;
    assign w_dy = i_lane.x >>> i_step;
    assign w_at = atan_q30(i_step);

    always_comb begin
        if (i_lane.y > 0) begin
            o_lane.x = i_lane.x + w_dx;
            o_lane.y = i_lane.y - w_dy;
            o_lane.z = i_lane.z + w_at;
        end else begin
            o_lane.x = i_lane.x - w_dx;
            o_lane.y = i_lane.y + w_dy;
            o_lane.z = i_lane.z - w_at;
        end
    end

endmodule
